@@ rtl/cursor_deque_defines.svh @@
// assertion macros included by cdq_back
`ifndef CURSOR_DEQUE_DEFINES_SVH
`define CURSOR_DEQUE_DEFINES_SVH

// condition that holds at every clock edge out of reset
`define CDQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequence that holds in the cycle after the antecedent
`define CDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/cdq_pkg.sv @@
package cdq_pkg;

  // decoded command kinds passed from front to back
  typedef enum logic [3:0] {
    CMD_PUSH_BACK,
    CMD_PUSH_FRONT,
    CMD_POP_BACK,
    CMD_POP_FRONT,
    CMD_JUMP,
    CMD_NEXT,
    CMD_PREV,
    CMD_RESET,
    CMD_WRITE,
    CMD_READ,
    CMD_NONE
  } cmd_kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_t;

  // one queued command
  typedef struct packed {
    cmd_kind_t          kind;
    logic signed [31:0] value;
    logic [3:0]         position;
  } cmd_t;

endpackage

@@ rtl/cdq_front.sv @@
module cdq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_value,
  input  logic [3:0]         in_position,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cdq_pkg::cmd_t      cmd
);

  // operation codes on the input channel
  localparam logic [3:0] OP_PUSH_BACK  = 4'd0;
  localparam logic [3:0] OP_PUSH_FRONT = 4'd1;
  localparam logic [3:0] OP_POP_BACK   = 4'd2;
  localparam logic [3:0] OP_POP_FRONT  = 4'd3;
  localparam logic [3:0] OP_JUMP       = 4'd4;
  localparam logic [3:0] OP_NEXT       = 4'd5;
  localparam logic [3:0] OP_PREV       = 4'd6;
  localparam logic [3:0] OP_RESET      = 4'd7;
  localparam logic [3:0] OP_WRITE      = 4'd8;
  localparam logic [3:0] OP_READ       = 4'd9;

  cdq_pkg::cmd_t      q_r [2];
  cdq_pkg::cmd_t      dec;
  logic               wp_r, wp_nxt;
  logic               rp_r, rp_nxt;
  logic [1:0]         n_r, n_nxt;
  logic               push, pop;

  // classify the incoming transaction
  always_comb begin
    dec.value    = in_value;
    dec.position = in_position;
    case (in_operation)
      OP_PUSH_BACK:  dec.kind = cdq_pkg::CMD_PUSH_BACK;
      OP_PUSH_FRONT: dec.kind = cdq_pkg::CMD_PUSH_FRONT;
      OP_POP_BACK:   dec.kind = cdq_pkg::CMD_POP_BACK;
      OP_POP_FRONT:  dec.kind = cdq_pkg::CMD_POP_FRONT;
      OP_JUMP:       dec.kind = cdq_pkg::CMD_JUMP;
      OP_NEXT:       dec.kind = cdq_pkg::CMD_NEXT;
      OP_PREV:       dec.kind = cdq_pkg::CMD_PREV;
      OP_RESET:      dec.kind = cdq_pkg::CMD_RESET;
      OP_WRITE:      dec.kind = cdq_pkg::CMD_WRITE;
      OP_READ:       dec.kind = cdq_pkg::CMD_READ;
      default:       dec.kind = cdq_pkg::CMD_NONE;
    endcase
  end

  // two-entry command queue
  assign in_ready  = (n_r != 2'd2);
  assign cmd_valid = (n_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    n_nxt  = n_r;
    if (push && !pop) begin
      n_nxt = n_r + 2'd1;
    end else if (pop && !push) begin
      n_nxt = n_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      n_r  <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      n_r  <= n_nxt;
    end
  end

  // queue payload
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

@@ rtl/cdq_back.sv @@
`include "cursor_deque_defines.svh"

module cdq_back #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cdq_pkg::cmd_t      cmd,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_cursor_data,
  output logic [3:0]         out_cursor_index,
  output logic               out_cursor_valid,
  output logic [4:0]         out_item_count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > 4) ? CW : 4;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW:0]   DEPTH_S = (PW + 1)'(DEPTH);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  typedef enum logic [2:0] {
    S_EXEC = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  logic [PW-1:0]        front_r, front_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [PW-1:0]        cursor_r, cursor_nxt;
  cdq_pkg::status_t     status_r, status_nxt;
  logic signed [31:0]   mem [DEPTH];
  logic signed [31:0]   rdata_r;
  logic                 wr_en;
  logic [PW-1:0]        wr_slot;
  logic                 exec;
  logic [CW-1:0]        cnt_dec;
  logic [CW-1:0]        cur_ext;
  logic [MW-1:0]        pos_ext;
  logic [PW-1:0]        fp_dec, fp_inc;

  // ring slot of an index counted from the front
  function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] fp,
                                            input logic [PW-1:0] idx);
    logic [PW:0] sum;
    sum = (PW + 1)'(fp) + (PW + 1)'(idx);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[PW-1:0];
  endfunction

  assign exec      = (state_r == S_EXEC) && cmd_valid;
  assign cmd_ready = (state_r == S_EXEC);
  assign cnt_dec   = count_r - CW'(1);
  assign cur_ext   = CW'(cursor_r);
  assign pos_ext   = MW'(cmd.position);
  assign fp_dec    = (front_r == '0) ? LAST_SLOT : front_r - PW'(1);
  assign fp_inc    = (front_r == LAST_SLOT) ? '0 : front_r + PW'(1);

  // carry out one command on pointers, count and cursor
  always_comb begin
    front_nxt  = front_r;
    count_nxt  = count_r;
    cursor_nxt = cursor_r;
    status_nxt = cdq_pkg::ST_OK;
    wr_en      = 1'b0;
    wr_slot    = slot_of(front_r, cursor_r);
    case (cmd.kind)
      cdq_pkg::CMD_PUSH_BACK: begin
        if (count_r == DEPTH_C) begin
          status_nxt = cdq_pkg::ST_FULL;
        end else begin
          wr_en     = 1'b1;
          wr_slot   = slot_of(front_r, count_r[PW-1:0]);
          count_nxt = count_r + CW'(1);
          if (count_r == '0) begin
            cursor_nxt = '0;
          end
        end
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (count_r == DEPTH_C) begin
          status_nxt = cdq_pkg::ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_slot    = fp_dec;
          front_nxt  = fp_dec;
          count_nxt  = count_r + CW'(1);
          cursor_nxt = (count_r == '0) ? '0 : cursor_r + PW'(1);
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (count_r == '0) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else begin
          count_nxt = cnt_dec;
          if (cnt_dec == '0) begin
            cursor_nxt = '0;
          end else if (cur_ext >= cnt_dec) begin
            cursor_nxt = PW'(cnt_dec - CW'(1));
          end
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (count_r == '0) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else begin
          front_nxt = fp_inc;
          count_nxt = cnt_dec;
          if (cnt_dec == '0 || cursor_r == '0) begin
            cursor_nxt = '0;
          end else begin
            cursor_nxt = cursor_r - PW'(1);
          end
        end
      end
      cdq_pkg::CMD_JUMP: begin
        if (count_r == '0 || pos_ext >= MW'(count_r)) begin
          status_nxt = cdq_pkg::ST_RANGE;
        end else begin
          cursor_nxt = pos_ext[PW-1:0];
        end
      end
      cdq_pkg::CMD_NEXT: begin
        if (count_r == '0) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else if (cur_ext + CW'(1) < count_r) begin
          cursor_nxt = cursor_r + PW'(1);
        end
      end
      cdq_pkg::CMD_PREV: begin
        if (count_r == '0) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else if (cursor_r != '0) begin
          cursor_nxt = cursor_r - PW'(1);
        end
      end
      cdq_pkg::CMD_RESET: begin
        cursor_nxt = '0;
      end
      cdq_pkg::CMD_WRITE: begin
        if (count_r == '0) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end else begin
          wr_en = 1'b1;
        end
      end
      cdq_pkg::CMD_READ: begin
        if (count_r == '0) begin
          status_nxt = cdq_pkg::ST_EMPTY;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer: execute, read the cursor element, hold the result
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_EXEC:  if (cmd_valid) state_nxt = S_READ;
      S_READ:  state_nxt = S_RESP;
      S_RESP:  if (out_ready) state_nxt = S_EXEC;
      default: state_nxt = S_EXEC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_EXEC;
      front_r  <= '0;
      count_r  <= '0;
      cursor_r <= '0;
      status_r <= cdq_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      if (exec) begin
        front_r  <= front_nxt;
        count_r  <= count_nxt;
        cursor_r <= cursor_nxt;
        status_r <= status_nxt;
      end
    end
  end

  // ring buffer storage
  always_ff @(posedge clk) begin
    if (exec && wr_en) begin
      mem[wr_slot] <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      rdata_r <= mem[slot_of(front_r, cursor_r)];
    end
  end

  // result channel
  assign out_valid        = (state_r == S_RESP);
  assign out_status       = status_r;
  assign out_cursor_valid = (count_r != '0);
  assign out_cursor_data  = out_cursor_valid ? rdata_r : '0;
  assign out_cursor_index = out_cursor_valid ? 4'(cursor_r) : 4'd0;
  assign out_item_count   = 5'(count_r);

  `CDQ_ASSERT_ALWAYS(a_count_bound, count_r <= DEPTH_C, "count above depth")
  `CDQ_ASSERT_ALWAYS(a_cursor_in_range, count_r == '0 || cur_ext < count_r, "cursor off the queue")
  `CDQ_ASSERT_NEXT(a_count_held, state_r != S_EXEC, $stable(count_r), "count moved outside execute")
  `CDQ_ASSERT_NEXT(a_full_no_change, exec && status_nxt == cdq_pkg::ST_FULL, $stable(count_r) && $stable(front_r), "full push changed state")

endmodule

@@ rtl/cursor_deque.sv @@
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------------
// in        | in_valid / in_ready  | in_operation, in_value, in_position
// out       | out_valid / out_ready| out_status, out_cursor_data, out_cursor_index,
//           |                      | out_cursor_valid, out_item_count
//
// each transaction passes through the back end in turn: execute (pointer update and
// ring buffer write), cursor element read from the single-port storage, result hold.
// a two-entry command queue in front keeps taking transactions while a result waits.
// reset is synchronous on rst_n low and clears pointers, count and cursor.
// out_ready low holds the result and the back end; the front queue fills, then in_ready drops.
module cursor_deque #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_operation,
  input  logic signed [31:0] in_value,
  input  logic [3:0]         in_position,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_cursor_data,
  output logic [3:0]         out_cursor_index,
  output logic               out_cursor_valid,
  output logic [4:0]         out_item_count
);

  logic          cmd_valid;
  logic          cmd_ready;
  cdq_pkg::cmd_t cmd;

  // decode and queue
  cdq_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_value     (in_value),
    .in_position  (in_position),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  // execute against the ring buffer
  cdq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (cmd_valid),
    .cmd_ready        (cmd_ready),
    .cmd              (cmd),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_cursor_data  (out_cursor_data),
    .out_cursor_index (out_cursor_index),
    .out_cursor_valid (out_cursor_valid),
    .out_item_count   (out_item_count)
  );

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = 16;
  // highest operation code the input field can carry
  localparam logic [3:0] OP_TOP = 4'hF;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SENDER_PAUSE_AT = 850;
  localparam int HOLD_OFF_AT = 300;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int REPORT_LIMIT = 10;

  // one result as the block reports it
  typedef struct packed {
    cdq_pkg::status_t   status;
    logic signed [31:0] data;
    logic [3:0]         index;
    logic               valid;
    logic [4:0]         count;
  } deque_result_t;

  // one row of the directed table
  typedef struct {
    logic [3:0]         op;
    logic signed [31:0] value;
    logic [3:0]         pos;
    int                 reps;
    bit                 typed;
    deque_result_t      want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_operation = '0;
  logic signed [31:0] in_value = '0;
  logic [3:0] in_position = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic signed [31:0] out_cursor_data;
  logic [3:0] out_cursor_index;
  logic out_cursor_valid;
  logic [4:0] out_item_count;

  cursor_deque #(.DEPTH(DEPTH)) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_value         (in_value),
    .in_position      (in_position),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_cursor_data  (out_cursor_data),
    .out_cursor_index (out_cursor_index),
    .out_cursor_valid (out_cursor_valid),
    .out_item_count   (out_item_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // shadow copy of the deque
  logic signed [31:0] ring [DEPTH];
  int unsigned head;
  int unsigned fill;
  int unsigned cur;

  deque_result_t pending_results[$];
  stim_row_t directed_rows[$];
  int mismatches = 0;
  int results_seen = 0;

  function automatic int unsigned ring_slot(input int unsigned idx);
    return (head + (idx % DEPTH)) % DEPTH;
  endfunction

  // apply one operation to the shadow deque and return what the block should report
  function automatic deque_result_t step_deque(input logic [3:0] op,
                                               input logic signed [31:0] val,
                                               input logic [3:0] pos);
    deque_result_t r;
    r = '0;
    r.status = cdq_pkg::ST_OK;
    case (op)
      cdq_pkg::CMD_PUSH_BACK: begin
        if (fill >= DEPTH) begin
          r.status = cdq_pkg::ST_FULL;
        end else begin
          ring[ring_slot(fill)] = val;
          if (fill == 0) cur = 0;
          fill++;
        end
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (fill >= DEPTH) begin
          r.status = cdq_pkg::ST_FULL;
        end else begin
          head = (head + DEPTH - 1) % DEPTH;
          ring[head] = val;
          if (fill == 0) cur = 0;
          else cur++;
          fill++;
        end
      end
      cdq_pkg::CMD_POP_BACK: begin
        if (fill == 0) begin
          r.status = cdq_pkg::ST_EMPTY;
        end else begin
          fill--;
          if (fill == 0) cur = 0;
          else if (cur >= fill) cur = fill - 1;
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (fill == 0) begin
          r.status = cdq_pkg::ST_EMPTY;
        end else begin
          head = (head + 1) % DEPTH;
          fill--;
          if (cur > 0) cur--;
          if (fill == 0) cur = 0;
        end
      end
      cdq_pkg::CMD_JUMP: begin
        if (fill == 0 || pos >= fill) r.status = cdq_pkg::ST_RANGE;
        else cur = pos;
      end
      cdq_pkg::CMD_NEXT: begin
        if (fill == 0) r.status = cdq_pkg::ST_EMPTY;
        else if (cur + 1 < fill) cur++;
      end
      cdq_pkg::CMD_PREV: begin
        if (fill == 0) r.status = cdq_pkg::ST_EMPTY;
        else if (cur > 0) cur--;
      end
      cdq_pkg::CMD_RESET: cur = 0;
      cdq_pkg::CMD_WRITE: begin
        if (fill == 0) r.status = cdq_pkg::ST_EMPTY;
        else ring[ring_slot(cur)] = val;
      end
      cdq_pkg::CMD_READ: begin
        if (fill == 0) r.status = cdq_pkg::ST_EMPTY;
      end
      default: ;
    endcase
    r.count = fill[4:0];
    r.valid = (fill > 0);
    r.index = (fill > 0) ? cur[3:0] : 4'd0;
    r.data  = (fill > 0) ? ring[ring_slot(cur)] : 32'sd0;
    return r;
  endfunction

  // idle length: none when calm, else mostly none or short, now and then long
  function automatic int pick_gap(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return 32'sd0;
      3: return -32'sd1;
      4: return $signed($urandom_range(0, 31)) - 32'sd16;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [3:0] op, input logic signed [31:0] value,
                         input logic [3:0] pos, input int reps, input bit typed,
                         input deque_result_t want);
    stim_row_t row;
    row.op = op;
    row.value = value;
    row.pos = pos;
    row.reps = reps;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  // present one transaction, wait for its acceptance and record what it should give
  task automatic offer(input logic [3:0] op, input logic signed [31:0] value,
                       input logic [3:0] pos, input int gap, input bit typed,
                       input deque_result_t want);
    deque_result_t r;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_value <= value;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    r = step_deque(op, value, pos);
    pending_results.push_back(typed ? want : r);
  endtask

  // sender: reset, directed table, random traffic, final drain
  initial begin
    stim_row_t row;
    bit calm;
    bit filling;
    int r;
    logic [3:0] op;
    logic [3:0] pos;

    foreach (ring[i]) ring[i] = '0;
    head = 0;
    fill = 0;
    cur = 0;

    // empty queue cases
    add_row(cdq_pkg::CMD_POP_BACK, 0, 0, 1, 1,
            '{cdq_pkg::ST_EMPTY, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_POP_FRONT, 0, 0, 1, 1,
            '{cdq_pkg::ST_EMPTY, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_NEXT, 0, 0, 1, 1,
            '{cdq_pkg::ST_EMPTY, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_PREV, 0, 0, 1, 1,
            '{cdq_pkg::ST_EMPTY, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_WRITE, 5, 0, 1, 1,
            '{cdq_pkg::ST_EMPTY, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_READ, 0, 0, 1, 1,
            '{cdq_pkg::ST_EMPTY, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_JUMP, 0, 0, 1, 1,
            '{cdq_pkg::ST_RANGE, 32'sd0, 4'd0, 1'b0, 5'd0});
    add_row(cdq_pkg::CMD_RESET, 0, 0, 1, 1,
            '{cdq_pkg::ST_OK, 32'sd0, 4'd0, 1'b0, 5'd0});
    // extremes of the data word, cursor follows a push at the front
    add_row(cdq_pkg::CMD_PUSH_BACK, 32'sh7fff_ffff, 0, 1, 1,
            '{cdq_pkg::ST_OK, 32'sh7fff_ffff, 4'd0, 1'b1, 5'd1});
    add_row(cdq_pkg::CMD_PUSH_FRONT, 32'sh8000_0000, 0, 1, 1,
            '{cdq_pkg::ST_OK, 32'sh7fff_ffff, 4'd1, 1'b1, 5'd2});
    add_row(cdq_pkg::CMD_JUMP, 0, 4'hF, 1, 1,
            '{cdq_pkg::ST_RANGE, 32'sh7fff_ffff, 4'd1, 1'b1, 5'd2});
    add_row(cdq_pkg::CMD_JUMP, 0, 4'h0, 1, 1,
            '{cdq_pkg::ST_OK, 32'sh8000_0000, 4'd0, 1'b1, 5'd2});
    // cursor walk with hold at both ends
    add_row(cdq_pkg::CMD_NEXT, 0, 0, 2, 0, '0);
    add_row(cdq_pkg::CMD_PREV, 0, 0, 2, 0, '0);
    add_row(cdq_pkg::CMD_WRITE, -32'sd1, 0, 1, 0, '0);
    add_row(cdq_pkg::CMD_READ, 0, 0, 1, 0, '0);
    // codes beyond the last operation
    add_row(OP_TOP, 32'sh5a5a_a5a5, 4'hA, 1, 0, '0);
    add_row(cdq_pkg::CMD_NONE, 0, 0, 1, 0, '0);
    // fill up, then push when full
    add_row(cdq_pkg::CMD_PUSH_BACK, 100, 0, 14, 0, '0);
    add_row(cdq_pkg::CMD_PUSH_BACK, 7, 0, 1, 0, '0);
    add_row(cdq_pkg::CMD_PUSH_FRONT, 8, 0, 1, 0, '0);
    // pop back onto the cursor, then drain from the front past empty
    add_row(cdq_pkg::CMD_JUMP, 0, 4'hF, 1, 0, '0);
    add_row(cdq_pkg::CMD_POP_BACK, 0, 0, 1, 0, '0);
    add_row(cdq_pkg::CMD_POP_FRONT, 0, 0, 17, 0, '0);
    // push front into an empty queue
    add_row(cdq_pkg::CMD_PUSH_FRONT, 9, 0, 1, 0, '0);
    add_row(cdq_pkg::CMD_POP_BACK, 0, 0, 1, 0, '0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      for (int k = 0; k < row.reps; k++)
        offer(row.op, row.value + k, row.pos, pick_gap(1'b0), row.typed, row.want);
    end

    // random traffic, drifting between filling and draining
    calm = 1'b0;
    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) calm = ($urandom_range(0, 3) == 0);
      if (n == SENDER_PAUSE_AT) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      if (fill >= DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (fill == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = 4'($urandom_range(cdq_pkg::CMD_NONE, OP_TOP));
      end else if (r < (filling ? 48 : 18)) begin
        op = $urandom_range(0, 1) ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_BACK;
      end else if (r < 63) begin
        op = $urandom_range(0, 1) ? cdq_pkg::CMD_POP_FRONT : cdq_pkg::CMD_POP_BACK;
      end else begin
        op = 4'($urandom_range(cdq_pkg::CMD_JUMP, cdq_pkg::CMD_READ));
      end
      if (fill > 0 && $urandom_range(0, 4) != 0) pos = 4'($urandom_range(0, fill - 1));
      else pos = 4'($urandom_range(0, 15));
      offer(op, pick_word(), pos, pick_gap(calm), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // drain and let any stray result show up
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // receiver: checks every result transaction, stalls at random, one long hold-off
  initial begin
    deque_result_t want;
    deque_result_t got;
    int stall_left;
    bit calm;

    stall_left = 0;
    calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    out_ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        got = '{cdq_pkg::status_t'(out_status), out_cursor_data, out_cursor_index,
                out_cursor_valid, out_item_count};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected result status=%0d data=%h index=%0d valid=%0b count=%0d",
                     $realtime, got.status, got.data, got.index, got.valid, got.count);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
              $display("%0t: result %0d expected status=%0d data=%h index=%0d valid=%0b count=%0d",
                       $realtime, results_seen, want.status, want.data, want.index,
                       want.valid, want.count);
              $display("  got status=%0d data=%h index=%0d valid=%0b count=%0d",
                       got.status, got.data, got.index, got.valid, got.count);
            end
          end
        end
        if (results_seen % 100 == 0) calm = ($urandom_range(0, 3) == 0);
        if (results_seen == HOLD_OFF_AT) stall_left = HOLD_OFF_CYCLES;
        else stall_left = pick_gap(calm);
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/cdq_pkg.sv
rtl/cdq_front.sv
rtl/cdq_back.sv
rtl/cursor_deque.sv
tb/tb.sv
